/* hdl/cbcc_pkg.sv */
// shared types, constants and helpers of the chunked body completion checker
package cbcc_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam int         HEX_RADIX = 16;
    localparam int         HEX_DIGIT_BITS = $clog2(HEX_RADIX);

    localparam logic [2:0] PH_SIZE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_DCR  = 3'd2;
    localparam logic [2:0] PH_DLF  = 3'd3;
    localparam logic [2:0] PH_LCR  = 3'd4;
    localparam logic [2:0] PH_LLF  = 3'd5;
    localparam logic [2:0] PH_EXT  = 3'd6;

    typedef struct packed {
        logic [2:0]           phase;
        logic [SIZE_BITS-1:0] size_accum;
        logic [SIZE_BITS-1:0] bytes_left;
        logic                 line_nonempty;
        logic                 digits_done;
        logic                 cr_pending;
        logic                 done_flag;
        logic                 error_flag;
    } cbcc_state_t;

    localparam cbcc_state_t STATE_INIT = '{
        phase:         PH_SIZE,
        size_accum:    '0,
        bytes_left:    '0,
        line_nonempty: 1'b0,
        digits_done:   1'b0,
        cr_pending:    1'b0,
        done_flag:     1'b0,
        error_flag:    1'b0
    };

    typedef struct packed {
        logic                      valid;
        logic [HEX_DIGIT_BITS-1:0] value;
    } cbcc_hex_t;

    // ascii hex digit decode, either case
    function automatic cbcc_hex_t hex_decode(input logic [7:0] c);
        cbcc_hex_t h;
        h.valid = 1'b1;
        h.value = '0;
        if (c >= 8'h30 && c <= 8'h39)
            h.value = HEX_DIGIT_BITS'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            h.value = HEX_DIGIT_BITS'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            h.value = HEX_DIGIT_BITS'(c - 8'h37);
        else
            h.valid = 1'b0;
        return h;
    endfunction

endpackage

/* hdl/cbcc_ifs.sv */
// request channels of the chunked body completion checker
interface cbcc_byte_if;
    import cbcc_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       start_of_body;

    modport source (output valid, output body_byte, output start_of_body, input ready);
    modport sink (input valid, input body_byte, input start_of_body, output ready);
endinterface

interface cbcc_status_if;
    logic valid;
    logic ready;
    logic complete;
    logic malformed;

    modport source (output valid, output complete, output malformed, input ready);
    modport sink (input valid, input complete, input malformed, output ready);
endinterface

/* hdl/chunked_body_completion_checker_core.sv */
// top level of the chunked body completion checker
// Takes a chunked HTTP message body one byte per request and returns one status
// request per byte: complete (the zero-size chunk and its CR LF were seen) and
// malformed (the framing broke). Both flags are sticky until a byte with
// start_of_body set restarts the parse; that byte is parsed as the first one.
// Throughput is one byte every clock cycle while the result side takes each status,
// set by the single parse state register, which updates as a byte moves from
// the input register to the result register. Status valid rises as the byte
// enters the result register, which a stalled result side can hold off.
// A stalled result side holds one finished status plus one waiting byte.
// Chunk sizes up to SIZE_BITS bits of hex are accepted; larger sizes,
// empty size lines and a missing CR LF after the data are all malformed.
module chunked_body_completion_checker_core
    import cbcc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cbcc_byte_if.sink     body,
    cbcc_status_if.source result
);

    // input register stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // parse state and result register
    cbcc_state_t state_reg;
    cbcc_state_t state_next;
    logic        out_valid_reg;
    logic        out_complete_reg;
    logic        out_malformed_reg;

    logic advance;
    logic body_take;

    // move the waiting byte into the result register when it is free
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign body.ready = !in_valid_reg || advance;
    assign body_take = body.valid && body.ready;

    cbcc_parse u_parse (
        .cur_state     (state_reg),
        .body_byte     (in_byte_reg),
        .start_of_body (in_start_reg),
        .next_state    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (body.ready) begin
            in_valid_reg <= body.valid;
        end
    end

    // byte payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (body_take) begin
            in_byte_reg  <= body.body_byte;
            in_start_reg <= body.start_of_body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= STATE_INIT;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_complete_reg  <= state_next.done_flag;
            out_malformed_reg <= state_next.error_flag;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.complete  = out_complete_reg;
    assign result.malformed = out_malformed_reg;

    // a body never reports complete and malformed together
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.done_flag && state_reg.error_flag))
        else $error("complete and malformed both set");

    // a waiting byte stays put until the result side frees up
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("waiting byte lost");

    // without a restart, done and error never clear
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_start_reg && (state_reg.done_flag || state_reg.error_flag)
        |=> $stable(state_reg))
        else $error("sticky state changed");

endmodule

/* hdl/cbcc_parse.sv */
// per-byte next-state logic of the chunked body parser
module cbcc_parse
    import cbcc_pkg::*;
(
    input  cbcc_state_t cur_state,
    input  logic [7:0]  body_byte,
    input  logic        start_of_body,
    output cbcc_state_t next_state
);

    // one size line byte that is not part of a line end
    function automatic cbcc_state_t line_byte(input cbcc_state_t s, input logic [7:0] c);
        cbcc_state_t r;
        cbcc_hex_t   h;
        r = s;
        h = hex_decode(c);
        if (s.phase != PH_EXT) begin
            if (c == CHAR_SEMI) begin
                r.phase = PH_EXT;
            end
            else begin
                r.line_nonempty = 1'b1;
                if (!s.digits_done) begin
                    if (!h.valid)
                        r.digits_done = 1'b1;
                    else if (s.size_accum[SIZE_BITS-1 -: HEX_DIGIT_BITS] != '0)
                        r.error_flag = 1'b1;
                    else
                        r.size_accum = {s.size_accum[SIZE_BITS-HEX_DIGIT_BITS-1:0], h.value};
                end
            end
        end
        return r;
    endfunction

    cbcc_state_t base;
    cbcc_state_t s;
    logic [SIZE_BITS-1:0] left_dec;

    assign base     = start_of_body ? STATE_INIT : cur_state;
    assign left_dec = base.bytes_left - SIZE_BITS'(1);

    always_comb
    begin
        s = base;
        if (!base.done_flag && !base.error_flag) begin
            unique case (base.phase)
                PH_SIZE, PH_EXT:
                begin
                    if (base.cr_pending && body_byte == CHAR_LF) begin
                        if (!base.line_nonempty) begin
                            s.error_flag = 1'b1;
                        end
                        else begin
                            s.bytes_left    = base.size_accum;
                            s.phase         = (base.size_accum == '0) ? PH_LCR : PH_DATA;
                            s.size_accum    = '0;
                            s.line_nonempty = 1'b0;
                            s.digits_done   = 1'b0;
                            s.cr_pending    = 1'b0;
                        end
                    end
                    else begin
                        // a lone cr is an ordinary line byte, never an error
                        if (base.cr_pending) begin
                            s.cr_pending = 1'b0;
                            s = line_byte(s, CHAR_CR);
                        end
                        if (body_byte == CHAR_CR)
                            s.cr_pending = 1'b1;
                        else
                            s = line_byte(s, body_byte);
                    end
                end
                PH_DATA:
                begin
                    s.bytes_left = left_dec;
                    if (left_dec == '0)
                        s.phase = PH_DCR;
                end
                PH_DCR:
                begin
                    if (body_byte == CHAR_CR) s.phase = PH_DLF;
                    else                      s.error_flag = 1'b1;
                end
                PH_DLF:
                begin
                    if (body_byte == CHAR_LF) s.phase = PH_SIZE;
                    else                      s.error_flag = 1'b1;
                end
                PH_LCR:
                begin
                    if (body_byte == CHAR_CR) s.phase = PH_LLF;
                    else                      s.error_flag = 1'b1;
                end
                PH_LLF:
                begin
                    if (body_byte == CHAR_LF) s.done_flag = 1'b1;
                    else                      s.error_flag = 1'b1;
                end
                default:
                begin
                    s.error_flag = 1'b1;
                end
            endcase
        end
    end

    assign next_state = s;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the chunked body completion checker core
module tb_top;
    import cbcc_pkg::*;

    localparam int ITEM_TARGET    = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;

    // one byte request as queued for the driver
    typedef struct {
        logic [7:0] value;
        bit         restart;
        bit         drain_first;   // hold off until every status has come back
    } body_req_t;

    typedef struct packed {
        logic complete;
        logic malformed;
    } body_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cbcc_byte_if   body_ch ();
    cbcc_status_if status_ch ();

    chunked_body_completion_checker_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .result (status_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus store and expected status store, keyed by byte sequence number
    body_req_t    pending_bytes[$];
    logic [7:0]   body_text[$];
    body_status_t expected_status[int];

    int bytes_taken;
    int status_seen;
    int send_gap;
    int hold_off;
    int idle_cycles;
    int mismatch_count;
    int body_count;
    int bodies_completed;
    int bodies_broken;
    int drain_pauses;
    bit tx_quiet;
    bit rx_quiet;

    // parse state of the chunked body predictor
    logic [2:0]           parse_phase;
    logic [SIZE_BITS-1:0] hex_accum;
    logic [SIZE_BITS-1:0] chunk_left;
    logic                 line_has_text;
    logic                 hex_run_over;
    logic                 saw_cr;
    logic                 body_done;
    logic                 body_broken;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic clear_parse();
        parse_phase   = PH_SIZE;
        hex_accum     = '0;
        chunk_left    = '0;
        line_has_text = 1'b0;
        hex_run_over  = 1'b0;
        saw_cr        = 1'b0;
        body_done     = 1'b0;
        body_broken   = 1'b0;
    endtask

    // a size line byte that is not part of the closing CR LF
    task automatic line_char(input logic [7:0] c);
        logic [3:0] nib;
        bit         is_hex;
        if (parse_phase == PH_EXT)
            return;
        if (c == CHAR_SEMI)
        begin
            parse_phase = PH_EXT;
            return;
        end
        line_has_text = 1'b1;
        if (hex_run_over)
            return;
        is_hex = 1'b1;
        nib    = c[3:0];
        if (c >= "0" && c <= "9")
            nib = c[3:0];
        else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            nib = c[3:0] + 4'd9;
        else
            is_hex = 1'b0;
        if (!is_hex)
            hex_run_over = 1'b1;
        else if (hex_accum[SIZE_BITS-1 -: HEX_DIGIT_BITS] != '0)
            body_broken = 1'b1;     // one more digit would not fit the counter
        else
            hex_accum = {hex_accum[SIZE_BITS-HEX_DIGIT_BITS-1:0], nib};
    endtask

    // advance the predicted parse by one accepted byte
    task automatic parse_step(input logic [7:0] c, input logic restart);
        if (restart)
            clear_parse();
        if (body_done || body_broken)
            return;
        case (parse_phase)
            PH_SIZE, PH_EXT:
            begin
                if (saw_cr)
                begin
                    if (c == CHAR_LF)
                    begin
                        if (!line_has_text)
                        begin
                            body_broken = 1'b1;
                            return;
                        end
                        chunk_left    = hex_accum;
                        parse_phase   = (hex_accum == '0) ? PH_LCR : PH_DATA;
                        hex_accum     = '0;
                        line_has_text = 1'b0;
                        hex_run_over  = 1'b0;
                        saw_cr        = 1'b0;
                        return;
                    end
                    // a lone CR is an ordinary line byte
                    saw_cr = 1'b0;
                    line_char(CHAR_CR);
                    if (body_broken)
                        return;
                end
                if (c == CHAR_CR)
                    saw_cr = 1'b1;
                else
                    line_char(c);
            end
            PH_DATA:
            begin
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0)
                    parse_phase = PH_DCR;
            end
            PH_DCR:
                if (c == CHAR_CR) parse_phase = PH_DLF; else body_broken = 1'b1;
            PH_DLF:
                if (c == CHAR_LF) parse_phase = PH_SIZE; else body_broken = 1'b1;
            PH_LCR:
                if (c == CHAR_CR) parse_phase = PH_LLF; else body_broken = 1'b1;
            PH_LLF:
                if (c == CHAR_LF) body_done = 1'b1; else body_broken = 1'b1;
            default:
                body_broken = 1'b1;
        endcase
    endtask

    // ---- body text building ----

    task automatic put_char(input logic [7:0] c);
        body_text.push_back(c);
    endtask

    task automatic put_crlf();
        put_char(CHAR_CR);
        put_char(CHAR_LF);
    endtask

    function automatic logic [7:0] rand_not_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CHAR_LF) ? 8'h2D : b;
    endfunction

    // hex digits of v in mixed case, after the given number of leading zeros
    task automatic put_hex(input logic [SIZE_BITS-1:0] v, input int zeros);
        int         top_nib;
        logic [3:0] nib;
        top_nib = 0;
        for (int i = 0; i < SIZE_BITS / 4; i++)
            if (v[i*4 +: 4] != 4'd0)
                top_nib = i;
        repeat (zeros) put_char("0");
        for (int i = top_nib; i >= 0; i--)
        begin
            nib = v[i*4 +: 4];
            if (nib < 4'd10)
                put_char(8'h30 + nib);
            else
                put_char(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
        end
    endtask

    // a size line of a well-formed chunk, with the optional oddities the parser allows
    task automatic put_size_line(input int len);
        if (len == 0 && $urandom_range(0, 5) == 0)
            put_char($urandom_range(0, 1) ? "g" : " ");    // no digits counts as zero
        else
            put_hex(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 5) == 0)
        begin
            // end the digit run with junk, sometimes a lone CR
            if ($urandom_range(0, 1))
            begin
                put_char(CHAR_CR);
                put_char(rand_not_lf());
            end
            else
                put_char("z");
            repeat ($urandom_range(0, 3)) put_char(rand_not_lf());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            put_char(CHAR_SEMI);
            repeat ($urandom_range(0, 6)) put_char(rand_not_lf());
        end
        put_crlf();
    endtask

    task automatic flush_body(input bit restart, input bit drain);
        foreach (body_text[i])
            pending_bytes.push_back('{value: body_text[i],
                                      restart: restart && (i == 0),
                                      drain_first: drain && (i == 0)});
        body_text.delete();
        body_count++;
    endtask

    // ---- byte driver and predictor ----

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        body_req_t req;
        bit        was_done;
        bit        was_broken;
        bit        taken_now;
        if (!rst_n)
        begin
            body_ch.valid         <= 1'b0;
            body_ch.body_byte     <= '0;
            body_ch.start_of_body <= 1'b0;
            send_gap              <= 0;
            tx_quiet              <= 1'b0;
            bytes_taken           <= 0;
            clear_parse();
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                tx_quiet <= !tx_quiet;
            taken_now = body_ch.valid && body_ch.ready;
            if (taken_now)
            begin
                was_done   = body_done && !body_ch.start_of_body;
                was_broken = body_broken && !body_ch.start_of_body;
                parse_step(body_ch.body_byte, body_ch.start_of_body);
                expected_status[bytes_taken] = '{complete: body_done,
                                                 malformed: body_broken};
                bytes_taken <= bytes_taken + 1;
                if (body_done && !was_done)
                    bodies_completed++;
                if (body_broken && !was_broken)
                    bodies_broken++;
            end
            if (!body_ch.valid || body_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    body_ch.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_bytes.size() != 0 &&
                         (!pending_bytes[0].drain_first ||
                          (bytes_taken == status_seen && !taken_now)))
                begin
                    req = pending_bytes.pop_front();
                    if (req.drain_first)
                        drain_pauses++;
                    body_ch.valid         <= 1'b1;
                    body_ch.body_byte     <= req.value;
                    body_ch.start_of_body <= req.restart;
                    send_gap <= tx_quiet ? 0 :
                                (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
                end
                else
                    body_ch.valid <= 1'b0;
            end
        end
    end

    // ---- status monitor and checker ----

    always @(posedge clk or negedge rst_n)
    begin : status_monitor
        body_status_t want;
        if (!rst_n)
        begin
            status_ch.ready <= 1'b0;
            hold_off        <= 0;
            rx_quiet        <= 1'b0;
            status_seen     <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rx_quiet <= !rx_quiet;
            if (status_ch.valid && status_ch.ready)
            begin
                if (status_seen == bytes_taken)
                    report_mismatch($sformatf("status %b/%b with no byte outstanding",
                                              status_ch.complete, status_ch.malformed));
                else
                begin
                    want = expected_status[status_seen];
                    if (status_ch.complete !== want.complete)
                        report_mismatch($sformatf("byte %0d: complete %b, expected %b",
                                                  status_seen, status_ch.complete,
                                                  want.complete));
                    if (status_ch.malformed !== want.malformed)
                        report_mismatch($sformatf("byte %0d: malformed %b, expected %b",
                                                  status_seen, status_ch.malformed,
                                                  want.malformed));
                    expected_status.delete(status_seen);
                    status_seen <= status_seen + 1;
                end
            end
            if (hold_off != 0)
            begin
                status_ch.ready <= 1'b0;
                hold_off        <= hold_off - 1;
            end
            else
            begin
                status_ch.ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 7) == 0)
                    hold_off <= pick_gap();
            end
        end
    end

    // ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (body_ch.valid && body_ch.ready) ||
            (status_ch.valid && status_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no request moved for %0d cycles, %0d of %0d statuses back",
                     idle_cycles, status_seen, bytes_taken);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int pick;
        int chunk_len;
        int at;

        // directed: zero chunk right away, then a byte that must be ignored
        put_char("0");
        put_crlf();
        put_crlf();
        flush_body(1'b1, 1'b0);
        put_char(8'hFF);
        flush_body(1'b0, 1'b0);
        // empty size part; the sender also waits here for every status
        put_crlf();
        flush_body(1'b1, 1'b1);
        // nine digits: the last one no longer fits the size counter
        put_char("1");
        put_hex('0, 7);
        flush_body(1'b1, 1'b0);
        // data byte followed by something other than CR
        put_char("1");
        put_crlf();
        put_char(CHAR_CR);
        put_char("Z");
        flush_body(1'b1, 1'b0);
        // no leading digits means size zero; then a wrong byte where CR belongs
        put_char("g");
        put_crlf();
        put_char("Q");
        flush_body(1'b1, 1'b0);

        // random bodies, mostly well-formed, the rest broken or noise
        while (pending_bytes.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                repeat ($urandom_range(0, 4))
                begin
                    chunk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                                            : $urandom_range(1, 12);
                    put_size_line(chunk_len);
                    repeat (chunk_len) put_char(8'($urandom_range(0, 255)));
                    put_crlf();
                end
                put_size_line(0);
                put_crlf();
                // break a quarter of them: flip, drop, add a byte or cut short
                if ($urandom_range(0, 3) == 0)
                begin
                    at = $urandom_range(1, body_text.size() - 1);
                    case ($urandom_range(0, 3))
                        0: body_text[at] = body_text[at] ^ 8'($urandom_range(1, 255));
                        1: body_text.delete(at);
                        2: body_text.insert(at, 8'($urandom_range(0, 255)));
                        default: body_text = body_text[0:at];
                    endcase
                end
                // bytes past the end are ignored
                repeat ($urandom_range(0, 2)) put_char(8'($urandom_range(0, 255)));
            end
            else if (pick < 78)
            begin
                // size overflow
                put_char("1");
                put_hex(32'($urandom) | 32'h1000_0000, 0);
                put_crlf();
                repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(0, 255)));
            end
            else if (pick < 84)
            begin
                // widest legal size, cut off by the next restart
                put_hex(($urandom_range(0, 2) == 0) ? '1 : (32'($urandom) | 32'h8000_0000),
                        $urandom_range(0, 2));
                put_crlf();
                repeat ($urandom_range(1, 30)) put_char(8'($urandom_range(0, 255)));
            end
            else if (pick < 90)
            begin
                // empty size part, maybe with an extension
                if ($urandom_range(0, 1))
                begin
                    put_char(CHAR_SEMI);
                    repeat ($urandom_range(0, 4)) put_char(rand_not_lf());
                end
                put_crlf();
                repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(0, 255)));
            end
            else
                repeat ($urandom_range(1, 16)) put_char(8'($urandom_range(0, 255)));
            flush_body($urandom_range(0, 19) != 0, $urandom_range(0, 24) == 0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || body_ch.valid)
            @(posedge clk);
        while (status_seen != bytes_taken)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d body bytes in %0d bodies, %0d statuses checked",
                 bytes_taken, body_count, status_seen);
        $display("Bodies seen complete: %0d, malformed: %0d, sender drain pauses: %0d",
                 bodies_completed, bodies_broken, drain_pauses);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
